// ----- src/lrutc_pkg.sv -----
`timescale 1ns / 1ps
package lrutc_pkg;

    localparam int KEY_W        = 32;
    localparam int STAMP_W      = 64;
    localparam int CAP_W        = 5;
    localparam int SLOT_FIELD_W = 4;
    localparam int SLOTS_DEF    = 16;
    localparam int SLOTS_MAX    = 64;
    localparam int IDX_W        = $clog2(SLOTS_MAX);
    localparam int CNT_W        = $clog2(SLOTS_MAX + 1);

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    typedef struct packed {
        logic [KEY_W-1:0] tile_x;
        logic [KEY_W-1:0] tile_y;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    evicted;
        logic [KEY_W-1:0]        evicted_x;
        logic [KEY_W-1:0]        evicted_y;
    } t_rsp;

    typedef struct packed {
        logic               vld;
        logic               found_v;
        logic [IDX_W-1:0]   found_idx;
        logic               free_v;
        logic [IDX_W-1:0]   free_idx;
        logic               vict_v;
        logic [IDX_W-1:0]   vict_idx;
        logic [STAMP_W-1:0] vict_stamp;
        logic [KEY_W-1:0]   vict_x;
        logic [KEY_W-1:0]   vict_y;
        logic [CNT_W-1:0]   in_use;
    } t_sweep;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key_x;
        logic [KEY_W-1:0]   key_y;
        logic [STAMP_W-1:0] stamp;
    } t_wr;

endpackage

// ----- src/lrutc_cell.sv -----
`timescale 1ns / 1ps
module lrutc_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lrutc_pkg::t_req i_req,
    input  lrutc_pkg::t_wr  i_wr,
    input  lrutc_pkg::t_sweep i_sweep,
    output lrutc_pkg::t_sweep o_sweep
);

    localparam logic [lrutc_pkg::IDX_W-1:0] MY_IDX = lrutc_pkg::IDX_W'(IDX);

    logic                            r_valid;
    logic [lrutc_pkg::KEY_W-1:0]     r_key_x;
    logic [lrutc_pkg::KEY_W-1:0]     r_key_y;
    logic [lrutc_pkg::STAMP_W-1:0]   r_stamp;
    lrutc_pkg::t_sweep               r_sweep;
    lrutc_pkg::t_sweep               n_sweep;
    logic                            w_sel;

    assign w_sel = i_wr.en && (i_wr.idx == MY_IDX);

    always_comb begin
        n_sweep = i_sweep;
        if (r_valid) begin
            n_sweep.in_use = i_sweep.in_use + lrutc_pkg::CNT_W'(1);
            if (!i_sweep.found_v && r_key_x == i_req.tile_x && r_key_y == i_req.tile_y) begin
                n_sweep.found_v   = 1'b1;
                n_sweep.found_idx = MY_IDX;
            end
            if (!i_sweep.vict_v || r_stamp < i_sweep.vict_stamp) begin
                n_sweep.vict_v     = 1'b1;
                n_sweep.vict_idx   = MY_IDX;
                n_sweep.vict_stamp = r_stamp;
                n_sweep.vict_x     = r_key_x;
                n_sweep.vict_y     = r_key_y;
            end
        end else if (!i_sweep.free_v) begin
            n_sweep.free_v   = 1'b1;
            n_sweep.free_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sweep <= '0;
        end else begin
            if (w_sel) begin
                r_valid <= 1'b1;
            end
            r_sweep <= n_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_key_x <= i_wr.key_x;
            r_key_y <= i_wr.key_y;
            r_stamp <= i_wr.stamp;
        end
    end

    assign o_sweep = r_sweep;

endmodule

// ----- src/lru_tile_cache_tags.sv -----
`timescale 1ns / 1ps
// Fully associative tag and LRU replacement engine for tile coordinates. One
// request is handled at a time: a lookup token walks the chain of slot cells,
// one cell per cycle, gathering hit, lowest free slot, occupancy and the oldest
// stamp; the end of the chain is registered and the decide state then writes
// the chosen slot and the result. The result is held in an output register, so
// the next request is accepted while the result waits; the decision itself
// waits while an earlier result is still unaccepted. Capacity may be written
// only while idle; zero acts as one and values above SLOTS act as SLOTS.
module lru_tile_cache_tags #(
    parameter int SLOTS = lrutc_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lrutc_pkg::t_req             i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lrutc_pkg::t_rsp             o_out,
    input  logic                        i_cfg_we,
    input  logic [lrutc_pkg::CAP_W-1:0] i_cfg_wdata
);

    localparam int CMP_W = lrutc_pkg::CNT_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    logic [lrutc_pkg::CAP_W-1:0]      r_capacity;
    logic [lrutc_pkg::STAMP_W-1:0]    r_access;
    logic [lrutc_pkg::STAMP_W-1:0]    r_stamp_req;
    lrutc_pkg::t_req                  r_key;
    logic                             r_launch_vld;
    lrutc_pkg::t_sweep                r_tail;
    logic                             r_out_valid;
    lrutc_pkg::t_rsp                  r_out;
    lrutc_pkg::t_rsp                  n_out;
    lrutc_pkg::t_wr                   w_wr;
    lrutc_pkg::t_sweep                w_head;
    lrutc_pkg::t_sweep                w_chain [SLOTS+1];
    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_commit;
    logic [CMP_W-1:0]                 w_cap_ext;
    logic [CMP_W-1:0]                 w_eff_cap;
    logic [CMP_W-1:0]                 w_in_use;
    logic [lrutc_pkg::IDX_W-1:0]      w_target;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == ST_DECIDE) && w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        w_head     = '0;
        w_head.vld = r_launch_vld;
    end

    assign w_chain[0] = w_head;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            lrutc_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (r_key),
                .i_wr    (w_wr),
                .i_sweep (w_chain[g]),
                .o_sweep (w_chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        w_cap_ext = CMP_W'(r_capacity);
        w_in_use  = CMP_W'(r_tail.in_use);
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(SLOTS)) begin
            w_eff_cap = CMP_W'(SLOTS);
        end else begin
            w_eff_cap = w_cap_ext;
        end

        n_out = '0;
        if (r_tail.found_v) begin
            w_target  = r_tail.found_idx;
            n_out.hit = 1'b1;
        end else if (w_in_use < w_eff_cap && r_tail.free_v) begin
            w_target = r_tail.free_idx;
        end else begin
            w_target        = r_tail.vict_v ? r_tail.vict_idx : '0;
            n_out.evicted   = 1'b1;
            n_out.evicted_x = r_tail.vict_x;
            n_out.evicted_y = r_tail.vict_y;
        end
        n_out.slot = w_target[lrutc_pkg::SLOT_FIELD_W-1:0];

        w_wr.en    = w_commit;
        w_wr.idx   = w_target;
        w_wr.key_x = r_key.tile_x;
        w_wr.key_y = r_key.tile_y;
        w_wr.stamp = r_stamp_req;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_chain[SLOTS].vld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_capacity   <= lrutc_pkg::CAPACITY_RESET;
            r_access     <= '0;
            r_launch_vld <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_launch_vld <= w_accept;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_access <= r_access + lrutc_pkg::STAMP_W'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key       <= i_in;
            r_stamp_req <= r_access + lrutc_pkg::STAMP_W'(1);
        end
        if (r_state == ST_SWEEP && w_chain[SLOTS].vld) begin
            r_tail <= w_chain[SLOTS];
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

endmodule
